// File: src/ucer_pkg.sv
package ucer_pkg;

  // Result actions as seen on the action port
  typedef enum logic [2:0] {
    ACT_SETUP_END = 3'd0,
    ACT_SET_ADDR  = 3'd1,
    ACT_REINIT    = 3'd2,
    ACT_ACK_RX    = 3'd3,
    ACT_FIFO_WORD = 3'd4,
    ACT_SEND_IN   = 3'd5,
    ACT_STALL     = 3'd6,
    ACT_CFG_BULK  = 3'd7
  } action_t;

  // Main operation of one classified poll
  typedef enum logic [2:0] {
    OP_NONE    = 3'd0,
    OP_STALL   = 3'd1,
    OP_ACK_END = 3'd2,
    OP_CONFIG  = 3'd3,
    OP_SEND    = 3'd4,
    OP_ADDR    = 3'd5
  } op_t;

  // Back-end sequencer steps, in emission order
  typedef enum logic [2:0] {
    S_SUE   = 3'd0,
    S_RADDR = 3'd1,
    S_RINIT = 3'd2,
    S_ACK   = 3'd3,
    S_MAIN  = 3'd4,
    S_CFG   = 3'd5,
    S_WORD  = 3'd6,
    S_SEND  = 3'd7
  } step_t;

  localparam logic [1:0] KIND_STD   = 2'd0;
  localparam logic [1:0] KIND_CLASS = 2'd1;

  localparam logic [7:0] REQ_GET_DESC    = 8'h06;
  localparam logic [7:0] REQ_SET_ADDR    = 8'h05;
  localparam logic [7:0] REQ_SET_CFG     = 8'h09;
  localparam logic [7:0] REQ_GET_MAX_LUN = 8'hFE;
  localparam logic [7:0] REQ_BOT_RESET   = 8'hFF;

  localparam logic [7:0] DESC_DEVICE = 8'h01;
  localparam logic [7:0] DESC_CONFIG = 8'h02;
  localparam logic [7:0] DESC_STRING = 8'h03;
  localparam logic [7:0] DESC_QUAL   = 8'h06;

  localparam logic [6:0] SETUP_LEN = 7'd8;

  localparam logic SRC_ROM = 1'b0;
  localparam logic SRC_LUN = 1'b1;

  localparam logic [7:0] DEV_START  = 8'd0;
  localparam logic [7:0] DEV_LEN    = 8'd18;
  localparam logic [7:0] CFG_START  = 8'd18;
  localparam logic [7:0] CFG_LEN    = 8'd32;
  localparam logic [7:0] QUAL_START = 8'd50;
  localparam logic [7:0] QUAL_LEN   = 8'd10;
  localparam int         STR_NUM    = 4;

  localparam logic [7:0] STR_START [STR_NUM] = '{8'd60, 8'd64, 8'd84, 8'd108};
  localparam logic [7:0] STR_LEN   [STR_NUM] = '{8'd4, 8'd20, 8'd24, 8'd10};

  localparam int ROM_SIZE = 118;

  localparam logic [7:0] DESC_ROM [ROM_SIZE] = '{
    // device
    8'h12, 8'h01, 8'h00, 8'h02, 8'h00, 8'h00, 8'h00, 8'h40, 8'h1C,
    8'h1C, 8'h20, 8'h00, 8'h00, 8'h02, 8'h01, 8'h02, 8'h03, 8'h01,
    // configuration, interface, two bulk endpoints
    8'h09, 8'h02, 8'h20, 8'h00, 8'h01, 8'h01, 8'h00, 8'hC0, 8'h32,
    8'h09, 8'h04, 8'h00, 8'h00, 8'h02, 8'h08, 8'h06, 8'h50, 8'h00,
    8'h07, 8'h05, 8'h81, 8'h02, 8'h00, 8'h02, 8'h00,
    8'h07, 8'h05, 8'h02, 8'h02, 8'h00, 8'h02, 8'h00,
    // device qualifier
    8'h0A, 8'h06, 8'h00, 8'h02, 8'h00, 8'h00, 8'h00, 8'h40, 8'h01, 8'h00,
    // string 0: language list
    8'h04, 8'h03, 8'h09, 8'h04,
    // string 1
    8'h14, 8'h03, 8'h46, 8'h00, 8'h72, 8'h00, 8'h65, 8'h00, 8'h65, 8'h00,
    8'h74, 8'h00, 8'h72, 8'h00, 8'h69, 8'h00, 8'h62, 8'h00, 8'h65, 8'h00,
    // string 2
    8'h18, 8'h03, 8'h46, 8'h00, 8'h6C, 8'h00, 8'h61, 8'h00, 8'h73, 8'h00,
    8'h68, 8'h00, 8'h20, 8'h00, 8'h44, 8'h00, 8'h72, 8'h00, 8'h69, 8'h00,
    8'h76, 8'h00, 8'h65, 8'h00,
    // string 3
    8'h0A, 8'h03, 8'h31, 8'h00, 8'h32, 8'h00, 8'h33, 8'h00, 8'h34, 8'h00
  };

  localparam int CMDQ_DEPTH = 2;

  typedef struct packed {
    logic        rx_ready;
    logic        tx_ready;
    logic        data_end;
    logic        setup_end;
    logic        bus_reset;
    logic [6:0]  setup_bytes;
    logic [7:0]  request_type;
    logic [7:0]  request_code;
    logic [15:0] request_value;
    logic [15:0] request_length;
  } poll_t;

  // One classified poll handed from front to back
  typedef struct packed {
    logic       setup_end;
    logic       bus_reset;
    logic       ack;
    op_t        op;
    logic       src;
    logic [7:0] offset;
    logic [7:0] chunk;
    logic       send_end;
    logic [6:0] address;
    logic       configured;
  } cmd_t;

  function automatic logic [7:0] rom_byte(input logic [7:0] pos);
    logic [7:0] r;
    r = 8'h00;
    if (pos < 8'(ROM_SIZE)) r = DESC_ROM[pos[6:0]];
    return r;
  endfunction

endpackage

// File: src/ucer_cmdq.sv
module ucer_cmdq
  import ucer_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic wr_en,
  input  cmd_t wr_cmd,
  output logic full,
  input  logic rd_en,
  output cmd_t rd_cmd,
  output logic empty
);

  localparam int PTR_W = (CMDQ_DEPTH > 1) ? $clog2(CMDQ_DEPTH) : 1;
  localparam int CNT_W = $clog2(CMDQ_DEPTH + 1);

  cmd_t             slots [CMDQ_DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             do_wr;
  logic             do_rd;

  assign full   = (count == CNT_W'(CMDQ_DEPTH));
  assign empty  = (count == '0);
  assign do_wr  = wr_en && !full;
  assign do_rd  = rd_en && !empty;
  assign rd_cmd = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_wr) begin
        slots[wr_ptr] <= wr_cmd;
        wr_ptr <= (wr_ptr == PTR_W'(CMDQ_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_rd) begin
        rd_ptr <= (rd_ptr == PTR_W'(CMDQ_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_wr && !do_rd) begin
        count <= count + 1'b1;
      end else if (do_rd && !do_wr) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

// File: src/ucer_front.sv
module ucer_front
  import ucer_pkg::*;
#(
  parameter int PACKET_BYTES = 64,
  parameter int STRING_COUNT = 4
) (
  input  logic  clk,
  input  logic  rst,
  input  logic  accept,
  input  poll_t poll,
  output logic  q_push,
  output cmd_t  q_cmd
);

  localparam logic [7:0] PKT = 8'(PACKET_BYTES);
  localparam logic [7:0] STR_CNT = 8'(STRING_COUNT);

  logic [1:0] prev_status_bits;
  logic       reply_source;
  logic [7:0] reply_offset;
  logic [7:0] reply_remaining;
  logic [6:0] held_address;
  logic       address_pending;
  logic       is_configured;

  logic       reply_source_next;
  logic [7:0] reply_offset_next;
  logic [7:0] reply_remaining_next;
  logic [6:0] held_address_next;
  logic       address_pending_next;
  logic       is_configured_next;

  logic        send_req;
  logic        req_src;
  logic [7:0]  req_start;
  logic [7:0]  req_len;
  logic [15:0] req_limit;
  logic [7:0]  len_c;
  logic [7:0]  chunk;
  logic        fall;
  logic [1:0]  kind;
  logic [7:0]  desc_type;
  logic [7:0]  desc_idx;
  cmd_t        cmd;

  always_comb begin
    cmd                  = '0;
    cmd.op               = OP_NONE;
    send_req             = 1'b0;
    req_src              = SRC_ROM;
    req_start            = 8'd0;
    req_len              = 8'd0;
    req_limit            = 16'hFFFF;
    reply_source_next    = reply_source;
    reply_offset_next    = reply_offset;
    reply_remaining_next = reply_remaining;
    held_address_next    = held_address;
    address_pending_next = address_pending;
    is_configured_next   = is_configured;
    kind                 = poll.request_type[6:5];
    desc_type            = poll.request_value[15:8];
    desc_idx             = poll.request_value[7:0];
    fall = (prev_status_bits[0] && !poll.tx_ready) || (prev_status_bits[1] && !poll.data_end);

    cmd.setup_end = poll.setup_end;
    cmd.bus_reset = poll.bus_reset;

    if (poll.bus_reset) begin
      held_address_next    = 7'd0;
      address_pending_next = 1'b0;
      is_configured_next   = 1'b0;
    end

    if (poll.rx_ready) begin
      cmd.ack = 1'b1;
      if (poll.setup_bytes == SETUP_LEN) begin
        if (kind == KIND_STD) begin
          priority if (poll.request_code == REQ_GET_DESC) begin
            req_limit = poll.request_length;
            priority if (desc_type == DESC_DEVICE) begin
              send_req  = 1'b1;
              req_start = DEV_START;
              req_len   = DEV_LEN;
            end else if (desc_type == DESC_CONFIG) begin
              send_req  = 1'b1;
              req_start = CFG_START;
              req_len   = CFG_LEN;
            end else if (desc_type == DESC_QUAL) begin
              send_req  = 1'b1;
              req_start = QUAL_START;
              req_len   = QUAL_LEN;
            end else if (desc_type == DESC_STRING && desc_idx < STR_CNT
                         && desc_idx < 8'(STR_NUM)) begin
              send_req  = 1'b1;
              req_start = STR_START[desc_idx[1:0]];
              req_len   = STR_LEN[desc_idx[1:0]];
            end else begin
              cmd.op = OP_STALL;
            end
          end else if (poll.request_code == REQ_SET_ADDR) begin
            held_address_next    = poll.request_value[6:0];
            address_pending_next = 1'b1;
            cmd.op               = OP_ACK_END;
          end else if (poll.request_code == REQ_SET_CFG) begin
            is_configured_next = 1'b1;
            cmd.op             = OP_CONFIG;
          end else begin
            cmd.op = OP_STALL;
          end
        end else if (kind == KIND_CLASS) begin
          if (poll.request_code == REQ_GET_MAX_LUN) begin
            send_req = 1'b1;
            req_src  = SRC_LUN;
            req_len  = 8'd1;
          end else if (poll.request_code == REQ_BOT_RESET) begin
            cmd.op = OP_ACK_END;
          end
        end
      end
    end else if (fall) begin
      if (reply_remaining != 8'd0) begin
        send_req  = 1'b1;
        req_src   = reply_source;
        req_start = reply_offset;
        req_len   = reply_remaining;
      end else if (address_pending_next) begin
        cmd.op               = OP_ADDR;
        cmd.address          = held_address_next;
        address_pending_next = 1'b0;
      end
    end

    // Clamp to host length, then to one packet
    len_c = ({8'd0, req_len} > req_limit) ? req_limit[7:0] : req_len;
    chunk = (len_c > PKT) ? PKT : len_c;
    if (send_req) begin
      cmd.op               = OP_SEND;
      cmd.src              = req_src;
      cmd.offset           = req_start;
      cmd.chunk            = chunk;
      cmd.send_end         = (len_c == chunk);
      reply_source_next    = req_src;
      reply_offset_next    = req_start + chunk;
      reply_remaining_next = len_c - chunk;
    end

    cmd.configured = is_configured_next;
  end

  assign q_cmd  = cmd;
  assign q_push = accept && (cmd.setup_end || cmd.bus_reset || cmd.ack || cmd.op != OP_NONE);

  always_ff @(posedge clk) begin
    if (rst) begin
      prev_status_bits <= 2'd0;
      reply_source     <= SRC_ROM;
      reply_offset     <= 8'd0;
      reply_remaining  <= 8'd0;
      held_address     <= 7'd0;
      address_pending  <= 1'b0;
      is_configured    <= 1'b0;
    end else if (accept) begin
      prev_status_bits <= {poll.data_end, poll.tx_ready};
      reply_source     <= reply_source_next;
      reply_offset     <= reply_offset_next;
      reply_remaining  <= reply_remaining_next;
      held_address     <= held_address_next;
      address_pending  <= address_pending_next;
      is_configured    <= is_configured_next;
    end
  end

endmodule

// File: src/ucer_back.sv
module ucer_back
  import ucer_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic [3:0]  max_lun,
  input  cmd_t        q_cmd,
  input  logic        q_empty,
  output logic        q_pop,
  input  logic        pop,
  output logic        empty,
  output logic [2:0]  action,
  output logic [63:0] data_word,
  output logic [3:0]  byte_count,
  output logic [6:0]  device_address,
  output logic        end_flag,
  output logic        configured,
  output logic        last
);

  function automatic logic [7:0] step_enables(input cmd_t c);
    logic [7:0] en;
    en          = '0;
    en[S_SUE]   = c.setup_end;
    en[S_RADDR] = c.bus_reset;
    en[S_RINIT] = c.bus_reset;
    en[S_ACK]   = c.ack;
    en[S_MAIN]  = (c.op == OP_STALL) || (c.op == OP_ACK_END) || (c.op == OP_CONFIG)
                  || (c.op == OP_ADDR);
    en[S_CFG]   = (c.op == OP_CONFIG);
    en[S_WORD]  = (c.op == OP_SEND) && (c.chunk != 8'd0);
    en[S_SEND]  = (c.op == OP_SEND);
    return en;
  endfunction

  // First enabled step at or above lo; 8 means none left
  function automatic logic [3:0] first_step(input logic [7:0] en, input logic [3:0] lo);
    logic [3:0] r;
    r = 4'd8;
    for (int i = 7; i >= 0; i--) begin
      if (en[i] && 4'(i) >= lo) r = 4'(i);
    end
    return r;
  endfunction

  logic        busy;
  step_t       step;
  step_t       step_next;
  cmd_t        cmd;
  logic [7:0]  done;
  logic [7:0]  done_next;
  logic        out_valid;
  action_t     out_action;
  logic [63:0] out_word;
  logic [3:0]  out_count;
  logic [6:0]  out_addr;
  logic        out_end;
  logic        out_cfg;
  logic        out_last;

  action_t     r_action;
  logic [63:0] r_word;
  logic [3:0]  r_count;
  logic [6:0]  r_addr;
  logic        r_end;
  logic [7:0]  diff;
  logic [3:0]  take;
  logic [7:0]  pos;
  logic [7:0]  byte_val;
  logic [3:0]  nxt_idx;
  logic [3:0]  ld_idx;
  logic        is_last;
  logic        fire;

  assign fire  = busy && (!out_valid || pop);
  assign q_pop = !busy && !q_empty;

  always_comb begin
    diff     = cmd.chunk - done;
    take     = (diff > 8'd8) ? 4'd8 : diff[3:0];
    r_word   = '0;
    byte_val = 8'd0;
    pos      = 8'd0;
    for (int i = 0; i < 8; i++) begin
      pos = cmd.offset + done + 8'(i);
      if (cmd.src == SRC_LUN) begin
        byte_val = (pos == 8'd0) ? {4'd0, max_lun} : 8'd0;
      end else begin
        byte_val = rom_byte(pos);
      end
      if (4'(i) < take) r_word[8*i +: 8] = byte_val;
    end
    done_next = (step == S_WORD) ? done + {4'd0, take} : done;

    if (step == S_WORD && done_next < cmd.chunk) begin
      nxt_idx = {1'b0, S_WORD};
    end else begin
      nxt_idx = first_step(step_enables(cmd), {1'b0, step} + 4'd1);
    end
    is_last   = nxt_idx[3];
    step_next = step_t'(nxt_idx[2:0]);
    ld_idx    = first_step(step_enables(q_cmd), 4'd0);

    r_action = ACT_SETUP_END;
    r_count  = 4'd0;
    r_addr   = 7'd0;
    r_end    = 1'b0;
    unique case (step)
      S_SUE:   r_action = ACT_SETUP_END;
      S_RADDR: r_action = ACT_SET_ADDR;
      S_RINIT: r_action = ACT_REINIT;
      S_ACK:   r_action = ACT_ACK_RX;
      S_MAIN: begin
        unique case (cmd.op)
          OP_STALL: r_action = ACT_STALL;
          OP_ADDR: begin
            r_action = ACT_SET_ADDR;
            r_addr   = cmd.address;
          end
          default: begin
            r_action = ACT_ACK_RX;
            r_end    = 1'b1;
          end
        endcase
      end
      S_CFG:   r_action = ACT_CFG_BULK;
      S_WORD: begin
        r_action = ACT_FIFO_WORD;
        r_count  = take;
      end
      S_SEND: begin
        r_action = ACT_SEND_IN;
        r_end    = cmd.send_end;
      end
      default: r_action = ACT_SETUP_END;
    endcase
    if (step != S_WORD) r_word = '0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy      <= 1'b0;
      out_valid <= 1'b0;
      step      <= S_SUE;
    end else begin
      if (fire) begin
        out_valid  <= 1'b1;
        out_action <= r_action;
        out_word   <= r_word;
        out_count  <= r_count;
        out_addr   <= r_addr;
        out_end    <= r_end;
        out_cfg    <= cmd.configured;
        out_last   <= is_last;
        done       <= done_next;
        if (is_last) begin
          busy <= 1'b0;
        end else begin
          step <= step_next;
        end
      end else if (pop && out_valid) begin
        out_valid <= 1'b0;
      end
      if (q_pop) begin
        busy <= 1'b1;
        cmd  <= q_cmd;
        step <= step_t'(ld_idx[2:0]);
        done <= 8'd0;
      end
    end
  end

  assign empty          = !out_valid;
  assign action         = out_action;
  assign data_word      = out_word;
  assign byte_count     = out_count;
  assign device_address = out_addr;
  assign end_flag       = out_end;
  assign configured     = out_cfg;
  assign last           = out_last;

endmodule

// File: src/usb_control_endpoint_responder.sv
// Control endpoint (endpoint 0) responder. Each beat pushed in is one poll of
// the endpoint: status bits, a bus reset flag and the fields of any received
// setup packet. The poll yields zero to nine result beats, popped in
// order, the final one marked by last: setup-end service, bus reset handling
// (set address 0, reinit storage), rx ack, then the request's own actions:
// descriptor replies as FIFO words of up to 8 bytes followed by a send,
// deferred set address, set configuration, get max LUN and bulk-only reset.
// A poll that calls for nothing gives no beat. Replies longer than
// PACKET_BYTES go out one packet per later falling TX-ready or data-end bit.
// The front classifies a poll in the cycle it is pushed and parks it
// in a two-entry command queue, so full rises only when two polls wait
// behind the back end. The back end fetches a command, then emits its result
// beats in order, holding while pop does not take the output beat, and takes
// the next command only after the last beat. The max_lun register is written
// through the cfg channel, which is always ready; write it only while idle.
module usb_control_endpoint_responder
  import ucer_pkg::*;
#(
  parameter int PACKET_BYTES = 64,
  parameter int STRING_COUNT = 4
) (
  input  logic        clk,
  input  logic        rst,
  // poll input queue
  input  logic        push,
  output logic        full,
  input  logic        rx_ready,
  input  logic        tx_ready,
  input  logic        data_end,
  input  logic        setup_end,
  input  logic        bus_reset,
  input  logic [6:0]  setup_bytes,
  input  logic [7:0]  request_type,
  input  logic [7:0]  request_code,
  input  logic [15:0] request_value,
  input  logic [15:0] request_length,
  // result output queue
  output logic        empty,
  input  logic        pop,
  output logic [2:0]  action,
  output logic [63:0] data_word,
  output logic [3:0]  byte_count,
  output logic [6:0]  device_address,
  output logic        end_flag,
  output logic        configured,
  output logic        last,
  // max_lun register write channel
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [3:0]  cfg_data
);

  logic [3:0] max_lun;
  poll_t      poll;
  logic       accept;
  logic       q_push;
  cmd_t       q_wr_cmd;
  cmd_t       q_rd_cmd;
  logic       q_full;
  logic       q_empty;
  logic       q_pop;

  // The register is always writable; hold the last beat written
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      max_lun <= 4'd0;
    end else if (cfg_valid && cfg_ready) begin
      max_lun <= cfg_data;
    end
  end

  // Accept a poll whenever the command queue has room
  assign full   = q_full;
  assign accept = push && !q_full;

  assign poll.rx_ready       = rx_ready;
  assign poll.tx_ready       = tx_ready;
  assign poll.data_end       = data_end;
  assign poll.setup_end      = setup_end;
  assign poll.bus_reset      = bus_reset;
  assign poll.setup_bytes    = setup_bytes;
  assign poll.request_type   = request_type;
  assign poll.request_code   = request_code;
  assign poll.request_value  = request_value;
  assign poll.request_length = request_length;

  ucer_front #(
    .PACKET_BYTES(PACKET_BYTES),
    .STRING_COUNT(STRING_COUNT)
  ) u_front (
    .clk   (clk),
    .rst   (rst),
    .accept(accept),
    .poll  (poll),
    .q_push(q_push),
    .q_cmd (q_wr_cmd)
  );

  ucer_cmdq u_cmdq (
    .clk   (clk),
    .rst   (rst),
    .wr_en (q_push),
    .wr_cmd(q_wr_cmd),
    .full  (q_full),
    .rd_en (q_pop),
    .rd_cmd(q_rd_cmd),
    .empty (q_empty)
  );

  ucer_back u_back (
    .clk           (clk),
    .rst           (rst),
    .max_lun       (max_lun),
    .q_cmd         (q_rd_cmd),
    .q_empty       (q_empty),
    .q_pop         (q_pop),
    .pop           (pop),
    .empty         (empty),
    .action        (action),
    .data_word     (data_word),
    .byte_count    (byte_count),
    .device_address(device_address),
    .end_flag      (end_flag),
    .configured    (configured),
    .last          (last)
  );

endmodule
